/* rtl/bet_pkg.sv */
// Package for the breakpoint envelope table: item structs, function and register codes,
// controller state type and default sizes. No dependencies.
package bet_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_EVENTS_DEF = 64;

    localparam logic [2:0] FN_SET    = 3'd0;
    localparam logic [2:0] FN_REMOVE = 3'd1;
    localparam logic [2:0] FN_CLEAR  = 3'd2;
    localparam logic [2:0] FN_EVAL   = 3'd3;
    localparam logic [2:0] FN_BLOCK  = 3'd4;

    localparam logic [1:0] REG_VALUE_MIN     = 2'd0;
    localparam logic [1:0] REG_VALUE_MAX     = 2'd1;
    localparam logic [1:0] REG_STEP_MODE     = 2'd2;
    localparam logic [1:0] REG_DISCRETE_MODE = 2'd3;

    typedef struct packed {
        logic [2:0]         func;
        logic [63:0]        frame;
        logic signed [31:0] point_value;
        logic [31:0]        frame_count;
        logic [31:0]        target;
        logic [6:0]         capacity;
    } t_in_item;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] result_value;
        logic [31:0]        frame_offset;
        logic [31:0]        event_target;
        logic [6:0]         point_count;
        logic               last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRD,
        S_SCMP,
        S_SHRD,
        S_SHWR,
        S_WRPT,
        S_RMRD,
        S_RMWR,
        S_DIV,
        S_CRD,
        S_CCMP,
        S_ERD,
        S_ECMP
    } t_state;

endpackage

/* rtl/bet_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module bet_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bet_muldiv.sv */
// Iterative floor(m * d / s) for d < s, one half-step per cycle.
// No dependencies.
module bet_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_m,
    input  logic [63:0] i_d,
    input  logic [63:0] i_s,
    output logic        o_done,
    output logic [33:0] o_q
);

    logic        r_busy, n_busy;
    logic        r_ph, n_ph;
    logic        r_done, n_done;
    logic [5:0]  r_b, n_b;
    logic [63:0] r_r, n_r;
    logic [33:0] r_q, n_q;
    logic [33:0] r_m, n_m;
    logic [63:0] r_d, n_d;
    logic [63:0] r_s, n_s;
    logic [64:0] w_sum;

    always_comb begin
        n_busy = r_busy;
        n_ph   = r_ph;
        n_done = 1'b0;
        n_b    = r_b;
        n_r    = r_r;
        n_q    = r_q;
        n_m    = r_m;
        n_d    = r_d;
        n_s    = r_s;
        w_sum  = r_ph ? ({1'b0, r_r} + {1'b0, r_d}) : {r_r, 1'b0};
        if (i_start) begin
            n_busy = 1'b1;
            n_ph   = 1'b0;
            n_b    = 6'd33;
            n_r    = '0;
            n_q    = '0;
            n_m    = {1'b0, i_m};
            n_d    = i_d;
            n_s    = i_s;
        end else if (r_busy) begin
            if (!r_ph) begin
                if (w_sum >= {1'b0, r_s}) begin
                    n_r = 64'(w_sum - {1'b0, r_s});
                    n_q = {r_q[32:0], 1'b1};
                end else begin
                    n_r = w_sum[63:0];
                    n_q = {r_q[32:0], 1'b0};
                end
                n_ph = 1'b1;
            end else begin
                if (r_m[r_b]) begin
                    if (w_sum >= {1'b0, r_s}) begin
                        n_r = 64'(w_sum - {1'b0, r_s});
                        n_q = r_q + 34'd1;
                    end else begin
                        n_r = w_sum[63:0];
                    end
                end
                n_ph = 1'b0;
                if (r_b == 6'd0) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_b = r_b - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_ph <= n_ph;
        r_b  <= n_b;
        r_r  <= n_r;
        r_q  <= n_q;
        r_m  <= n_m;
        r_d  <= n_d;
        r_s  <= n_s;
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

/* rtl/breakpoint_envelope_table.sv */
// Breakpoint envelope table top level: APB registers, controller and point memories.
// Depends on bet_pkg, bet_ram and bet_muldiv.
//
// Usage: drive i_item and raise start; the item is taken at an edge where start is high
// and busy is low. Every result appears for one cycle with o_strobe high; results
// cannot be held off. Set, remove, clear and evaluate give one result; evaluate block
// gives one to capacity results (at most MAX_EVENTS), the final one marked by last.
// Clear and items refused on entry answer straight from idle; set and remove scan the
// table point by point, then shift each moved point; evaluate scans point by point and
// then runs the multiply-divide unit when interpolating. Evaluate block adds a counting
// pass and an emitting pass over the points. The point memories have one read and one
// write port, which bounds the scan speed.
// Registers (APB, 32-bit, byte address 4*i): value_min, value_max, step_mode,
// discrete_mode. Write registers only while busy is low and no results are pending.
// Reset empties the table and restores register defaults; the memories need no clearing.
module breakpoint_envelope_table #(
    parameter int MAX_POINTS = bet_pkg::MAX_POINTS_DEF,
    parameter int MAX_EVENTS = bet_pkg::MAX_EVENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bet_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output bet_pkg::t_out_item o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic signed [31:0] r_vmin, r_vmax;
    logic               r_step, r_disc;

    bet_pkg::t_state    r_state, n_state;
    bet_pkg::t_in_item  r_op, n_op;
    bet_pkg::t_out_item r_out, n_out;
    logic               r_strobe, n_strobe;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_j, n_j;
    logic [63:0]        r_lf, n_lf;
    logic signed [31:0] r_lv, n_lv;
    logic signed [31:0] r_val, n_val;
    logic               r_neg, n_neg;
    logic [6:0]         r_cap, n_cap;
    logic [6:0]         r_req, n_req;
    logic [6:0]         r_n, n_n;
    logic [63:0]        r_endf, n_endf;

    logic               w_we;
    logic [CW-1:0]      w_waddr, w_raddr;
    logic [63:0]        w_wfrm, rd_frame;
    logic [31:0]        w_wval, rd_value;

    logic               w_at_end, w_ge, w_gt, w_eq, w_is_eval, w_stop, w_res, w_match;
    logic               w_inb, w_bad, w_int, w_need_div, w_full_ok, w_rm_done;
    logic               w_elast;
    logic signed [31:0] w_ev_val, w_div_val;
    logic signed [32:0] w_diff;
    logic [32:0]        w_mag;
    logic [64:0]        w_endsum;
    logic               w_div_start, w_div_done;
    logic [33:0]        w_q;
    logic               w_cfg_wr;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmin <= 32'sh8000_0000;
            r_vmax <= 32'sh7FFF_FFFF;
            r_step <= 1'b0;
            r_disc <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                bet_pkg::REG_VALUE_MIN:     r_vmin <= pwdata;
                bet_pkg::REG_VALUE_MAX:     r_vmax <= pwdata;
                bet_pkg::REG_STEP_MODE:     r_step <= pwdata[0];
                bet_pkg::REG_DISCRETE_MODE: r_disc <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            bet_pkg::REG_VALUE_MIN:     prdata = r_vmin;
            bet_pkg::REG_VALUE_MAX:     prdata = r_vmax;
            bet_pkg::REG_STEP_MODE:     prdata = {31'd0, r_step};
            bet_pkg::REG_DISCRETE_MODE: prdata = {31'd0, r_disc};
            default:                    prdata = '0;
        endcase
    end

    // point memories
    bet_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_frames (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr[AW-1:0]),
        .i_wdata (w_wfrm),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (rd_frame)
    );

    bet_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_values (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr[AW-1:0]),
        .i_wdata (w_wval),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (rd_value)
    );

    bet_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_m     (w_mag),
        .i_d     (r_op.frame - r_lf),
        .i_s     (rd_frame - r_lf),
        .o_done  (w_div_done),
        .o_q     (w_q)
    );

    // shared decisions
    always_comb begin
        w_at_end  = (r_idx == r_cnt);
        w_ge      = (rd_frame >= r_op.frame);
        w_gt      = (rd_frame > r_op.frame);
        w_eq      = (rd_frame == r_op.frame);
        w_is_eval = (r_op.func == bet_pkg::FN_EVAL) || (r_op.func == bet_pkg::FN_BLOCK);
        w_stop    = w_is_eval ? w_gt : w_ge;
        w_res     = ((r_state == bet_pkg::S_SRD) && w_at_end)
                 || ((r_state == bet_pkg::S_SCMP) && w_stop);
        w_match   = (r_state == bet_pkg::S_SCMP) && w_eq;
        w_full_ok = (r_cnt < CW'(MAX_POINTS));
        w_rm_done = ((r_j + CW'(1)) >= r_cnt);
        w_inb     = (i_item.point_value >= r_vmin) && (i_item.point_value <= r_vmax);
        w_endsum  = {1'b0, i_item.frame} + {33'd0, i_item.frame_count};
        w_bad     = (i_item.frame_count == 32'd0) || (i_item.capacity == 7'd0)
                 || w_endsum[64];
        w_int     = (rd_frame > r_op.frame) && (rd_frame < r_endf);
        w_elast   = ((r_n + 7'd1) == r_req);
        w_need_div = (r_state == bet_pkg::S_SCMP) && w_stop && (r_idx != '0)
                  && !(r_step || r_disc);
        if (r_cnt == '0) begin
            w_ev_val = '0;
        end else if ((r_state == bet_pkg::S_SCMP) && (r_idx == '0)) begin
            w_ev_val = rd_value;
        end else begin
            w_ev_val = r_lv;
        end
        w_diff      = {rd_value[31], rd_value} - {r_lv[31], r_lv};
        w_mag       = w_diff[32] ? 33'(-w_diff) : w_diff;
        w_div_start = w_res && w_is_eval && w_need_div;
        w_div_val   = r_neg ? (r_lv - w_q[31:0]) : (r_lv + w_q[31:0]);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bet_pkg::S_IDLE: begin
                if (start) begin
                    case (i_item.func)
                        bet_pkg::FN_SET:    n_state = w_inb ? bet_pkg::S_SRD : bet_pkg::S_IDLE;
                        bet_pkg::FN_REMOVE: n_state = bet_pkg::S_SRD;
                        bet_pkg::FN_EVAL:   n_state = bet_pkg::S_SRD;
                        bet_pkg::FN_BLOCK:  n_state = w_bad ? bet_pkg::S_IDLE : bet_pkg::S_SRD;
                        default:            n_state = bet_pkg::S_IDLE;
                    endcase
                end
            end
            bet_pkg::S_SRD, bet_pkg::S_SCMP: begin
                if (w_res) begin
                    case (r_op.func)
                        bet_pkg::FN_SET: begin
                            if (w_match) n_state = bet_pkg::S_IDLE;
                            else if (w_full_ok) n_state = bet_pkg::S_SHRD;
                            else n_state = bet_pkg::S_IDLE;
                        end
                        bet_pkg::FN_REMOVE: begin
                            n_state = w_match ? bet_pkg::S_RMRD : bet_pkg::S_IDLE;
                        end
                        bet_pkg::FN_EVAL: begin
                            n_state = w_need_div ? bet_pkg::S_DIV : bet_pkg::S_IDLE;
                        end
                        default: begin
                            n_state = w_need_div ? bet_pkg::S_DIV : bet_pkg::S_CRD;
                        end
                    endcase
                end else if (r_state == bet_pkg::S_SRD) begin
                    n_state = bet_pkg::S_SCMP;
                end else begin
                    n_state = bet_pkg::S_SRD;
                end
            end
            bet_pkg::S_SHRD: n_state = (r_j == r_idx) ? bet_pkg::S_WRPT : bet_pkg::S_SHWR;
            bet_pkg::S_SHWR: n_state = bet_pkg::S_SHRD;
            bet_pkg::S_WRPT: n_state = bet_pkg::S_IDLE;
            bet_pkg::S_RMRD: n_state = w_rm_done ? bet_pkg::S_IDLE : bet_pkg::S_RMWR;
            bet_pkg::S_RMWR: n_state = bet_pkg::S_RMRD;
            bet_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = (r_op.func == bet_pkg::FN_BLOCK) ? bet_pkg::S_CRD
                                                               : bet_pkg::S_IDLE;
                end
            end
            bet_pkg::S_CRD: begin
                if (w_at_end) begin
                    n_state = (r_req == 7'd1) ? bet_pkg::S_IDLE : bet_pkg::S_ERD;
                end else begin
                    n_state = bet_pkg::S_CCMP;
                end
            end
            bet_pkg::S_CCMP: n_state = bet_pkg::S_CRD;
            bet_pkg::S_ERD:  n_state = w_at_end ? bet_pkg::S_IDLE : bet_pkg::S_ECMP;
            bet_pkg::S_ECMP: n_state = (w_int && w_elast) ? bet_pkg::S_IDLE : bet_pkg::S_ERD;
            default:         n_state = bet_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_op     = r_op;
        n_out    = '0;
        n_strobe = 1'b0;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_j      = r_j;
        n_lf     = r_lf;
        n_lv     = r_lv;
        n_val    = r_val;
        n_neg    = r_neg;
        n_cap    = r_cap;
        n_req    = r_req;
        n_n      = r_n;
        n_endf   = r_endf;
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_wfrm   = r_op.frame;
        w_wval   = r_op.point_value;
        case (r_state)
            bet_pkg::S_SHRD: w_raddr = r_j - CW'(1);
            bet_pkg::S_RMRD: w_raddr = r_j + CW'(1);
            default:         w_raddr = r_idx;
        endcase
        n_out.last = 1'b1;
        case (r_state)
            bet_pkg::S_IDLE: begin
                if (start) begin
                    n_op   = i_item;
                    n_idx  = '0;
                    n_cap  = (i_item.capacity > 7'(MAX_EVENTS)) ? 7'(MAX_EVENTS)
                                                                 : i_item.capacity;
                    n_endf = w_endsum[63:0];
                    case (i_item.func)
                        bet_pkg::FN_SET:    n_strobe = !w_inb;
                        bet_pkg::FN_REMOVE: ;
                        bet_pkg::FN_EVAL:   ;
                        bet_pkg::FN_CLEAR: begin
                            n_cnt    = '0;
                            n_strobe = 1'b1;
                            n_out.ok = 1'b1;
                        end
                        bet_pkg::FN_BLOCK:  n_strobe = w_bad;
                        default:            n_strobe = 1'b1;
                    endcase
                end
            end
            bet_pkg::S_SRD, bet_pkg::S_SCMP: begin
                if (w_res) begin
                    case (r_op.func)
                        bet_pkg::FN_SET: begin
                            if (w_match) begin
                                w_we     = 1'b1;
                                n_strobe = 1'b1;
                                n_out.ok = 1'b1;
                            end else if (w_full_ok) begin
                                n_j = r_cnt;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        bet_pkg::FN_REMOVE: begin
                            if (w_match) begin
                                n_j = r_idx;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        bet_pkg::FN_EVAL: begin
                            n_neg = w_diff[32];
                            if (!w_need_div) begin
                                n_strobe           = 1'b1;
                                n_out.ok           = 1'b1;
                                n_out.result_value = w_ev_val;
                            end
                        end
                        default: begin
                            n_neg = w_diff[32];
                            n_val = w_ev_val;
                            n_idx = '0;
                            n_req = 7'd1;
                        end
                    endcase
                end else if (r_state == bet_pkg::S_SCMP) begin
                    n_lf  = rd_frame;
                    n_lv  = rd_value;
                    n_idx = r_idx + CW'(1);
                end
            end
            bet_pkg::S_SHWR: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wfrm  = rd_frame;
                w_wval  = rd_value;
                n_j     = r_j - CW'(1);
            end
            bet_pkg::S_WRPT: begin
                w_we     = 1'b1;
                n_cnt    = r_cnt + CW'(1);
                n_strobe = 1'b1;
                n_out.ok = 1'b1;
            end
            bet_pkg::S_RMRD: begin
                if (w_rm_done) begin
                    n_cnt    = r_cnt - CW'(1);
                    n_strobe = 1'b1;
                    n_out.ok = 1'b1;
                end
            end
            bet_pkg::S_RMWR: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wfrm  = rd_frame;
                w_wval  = rd_value;
                n_j     = r_j + CW'(1);
            end
            bet_pkg::S_DIV: begin
                if (w_div_done) begin
                    if (r_op.func == bet_pkg::FN_BLOCK) begin
                        n_val = w_div_val;
                        n_idx = '0;
                        n_req = 7'd1;
                    end else begin
                        n_strobe           = 1'b1;
                        n_out.ok           = 1'b1;
                        n_out.result_value = w_div_val;
                    end
                end
            end
            bet_pkg::S_CRD: begin
                if (w_at_end) begin
                    n_strobe           = 1'b1;
                    n_out.ok           = 1'b1;
                    n_out.result_value = r_val;
                    n_out.event_target = r_op.target;
                    n_out.last         = (r_req == 7'd1);
                    n_idx              = '0;
                    n_n                = 7'd1;
                end
            end
            bet_pkg::S_CCMP: begin
                if (w_int && (r_req < r_cap)) begin
                    n_req = r_req + 7'd1;
                end
                n_idx = r_idx + CW'(1);
            end
            bet_pkg::S_ECMP: begin
                if (w_int) begin
                    n_strobe           = 1'b1;
                    n_out.ok           = 1'b1;
                    n_out.result_value = rd_value;
                    n_out.frame_offset = 32'(rd_frame - r_op.frame);
                    n_out.event_target = r_op.target;
                    n_out.last         = w_elast;
                    n_n                = r_n + 7'd1;
                end
                n_idx = r_idx + CW'(1);
            end
            default: ;
        endcase
        n_out.point_count = 7'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bet_pkg::S_IDLE;
            r_strobe <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_cnt    <= n_cnt;
        end
        r_op   <= n_op;
        r_out  <= n_out;
        r_idx  <= n_idx;
        r_j    <= n_j;
        r_lf   <= n_lf;
        r_lv   <= n_lv;
        r_val  <= n_val;
        r_neg  <= n_neg;
        r_cap  <= n_cap;
        r_req  <= n_req;
        r_n    <= n_n;
        r_endf <= n_endf;
    end

    assign busy     = (r_state != bet_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule
